### hw/rtl/xml_end_tag_recognizer_core_macros.svh
// Assertion macros used by the checker file of the end tag recognizer.
// No dependencies; take it in by include with the bare file name.
`ifndef XML_END_TAG_RECOGNIZER_CORE_MACROS_SVH
`define XML_END_TAG_RECOGNIZER_CORE_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define XETR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define XETR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/xetr_pkg.sv
// Shared types, codes and character classes for the XML end tag recognizer.
// No dependencies.
`default_nettype none

package xetr_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    typedef logic [2:0] err_code_t;

    localparam err_code_t ERR_OK       = 3'd0;
    localparam err_code_t ERR_EMPTY    = 3'd1;
    localparam err_code_t ERR_NO_OPEN  = 3'd2;
    localparam err_code_t ERR_UNTERM   = 3'd3;
    localparam err_code_t ERR_BAD_NAME = 3'd4;
    localparam err_code_t ERR_EXTRA    = 3'd5;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        last_byte;
        logic [31:0] start_offset;
    } xetr_item_t;

    typedef struct packed {
        logic        matched;
        err_code_t   error_code;
        logic [31:0] error_offset;
        logic [31:0] tag_begin;
        logic [31:0] raw_end;
        logic [31:0] name_begin;
        logic [31:0] name_limit;
    } xetr_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_name_first(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c == CH_UNDER) || (c == CH_COLON);
    endfunction

    function automatic logic is_name_next(input logic [7:0] c);
        return is_name_first(c) || (c >= 8'h30 && c <= 8'h39)
            || (c == CH_DASH) || (c == CH_DOT);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/xetr_in_stage.sv
// Input register of the end tag recognizer: holds one byte transaction.
// Depends on xetr_pkg.
`default_nettype none

module xetr_in_stage
    import xetr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        last_byte,
    input  wire logic [31:0] start_offset,
    input  wire logic        fire,
    output logic             item_valid,
    output xetr_item_t       item
);

    logic       valid_reg;
    xetr_item_t item_reg;
    logic       load;

    // Take a new byte when the register is empty or drains this cycle.
    assign load     = !valid_reg || fire;
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg.text_byte    <= text_byte;
            item_reg.last_byte    <= last_byte;
            item_reg.start_offset <= start_offset;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### hw/rtl/xetr_parser.sv
// Per-byte tag scanner: phase machine, captured offsets and the verdict logic.
// Depends on xetr_pkg.
`default_nettype none

module xetr_parser
    import xetr_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire xetr_item_t  item,
    output xetr_result_t     result
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SLASH,
        PH_NSTART,
        PH_NAME,
        PH_TRAIL,
        PH_WAITGT,
        PH_DONE
    } phase_t;

    typedef logic [OFFSET_BITS-1:0] off_t;

    localparam off_t ONE = off_t'(1);
    localparam off_t TWO = off_t'(2);

    phase_t    phase_reg, phase_next;
    logic      started_reg;
    err_code_t pend_reg, pend_next;
    off_t      off_reg;
    off_t      lead_reg, lead_next;
    off_t      stop_reg, stop_next;
    off_t      close_reg, close_next;

    off_t                     base;
    off_t                     cur;
    logic [OFFSET_BITS+31:0]  base_ext;
    logic [7:0]               c;

    function automatic logic [31:0] cut(input off_t v);
        logic [OFFSET_BITS+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

    assign c        = item.text_byte;
    assign base_ext = {{OFFSET_BITS{1'b0}}, item.start_offset};
    assign base     = base_ext[OFFSET_BITS-1:0];
    // Offset of the byte under inspection; sample the base on the first byte.
    assign cur      = started_reg ? off_reg : base;

    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        lead_next  = lead_reg;
        stop_next  = stop_reg;
        close_next = close_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!is_blank(c))
                begin
                    lead_next = cur;
                    if (c == CH_LT)
                    begin
                        phase_next = PH_SLASH;
                    end
                    else
                    begin
                        pend_next  = ERR_NO_OPEN;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    phase_next = PH_NSTART;
                end
                else
                begin
                    pend_next  = ERR_NO_OPEN;
                    phase_next = PH_DONE;
                end
            end
            PH_NSTART:
            begin
                if (is_name_first(c))
                begin
                    phase_next = PH_NAME;
                end
                else
                begin
                    pend_next  = ERR_BAD_NAME;
                    phase_next = (c == CH_GT) ? PH_DONE : PH_WAITGT;
                end
            end
            PH_NAME:
            begin
                if (!is_name_next(c))
                begin
                    stop_next = cur;
                    if (c == CH_GT)
                    begin
                        close_next = cur;
                        pend_next  = ERR_OK;
                        phase_next = PH_DONE;
                    end
                    else if (is_blank(c))
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        pend_next  = ERR_EXTRA;
                        phase_next = PH_WAITGT;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (c == CH_GT)
                begin
                    close_next = cur;
                    pend_next  = ERR_OK;
                    phase_next = PH_DONE;
                end
                else if (!is_blank(c))
                begin
                    pend_next  = ERR_EXTRA;
                    phase_next = PH_WAITGT;
                end
            end
            PH_WAITGT:
            begin
                if (c == CH_GT)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Verdict as seen after this byte; used only on a last byte.
    always_comb
    begin
        result = '0;
        if (phase_next == PH_LEAD)
        begin
            result.error_code   = ERR_EMPTY;
            result.error_offset = cut(cur + ONE);
        end
        else if (phase_next == PH_SLASH)
        begin
            result.error_code   = ERR_NO_OPEN;
            result.error_offset = cut(lead_next);
        end
        else if (phase_next != PH_DONE)
        begin
            result.error_code   = ERR_UNTERM;
            result.error_offset = cut(lead_next);
        end
        else
        begin
            result.error_code = pend_next;
            case (pend_next)
                ERR_OK:
                begin
                    result.matched      = 1'b1;
                    result.error_offset = cut(lead_next);
                    result.tag_begin    = cut(lead_next);
                    result.raw_end      = cut(close_next + ONE);
                    result.name_begin   = cut(lead_next + TWO);
                    result.name_limit   = cut(stop_next);
                end
                ERR_BAD_NAME:
                begin
                    result.error_offset = cut(lead_next + TWO);
                end
                ERR_EXTRA:
                begin
                    result.error_offset = cut(stop_next);
                end
                default:
                begin
                    result.error_offset = cut(lead_next);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            started_reg <= 1'b0;
            pend_reg    <= ERR_OK;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                // Drop the message state; the next byte opens a new message.
                phase_reg   <= PH_LEAD;
                started_reg <= 1'b0;
                pend_reg    <= ERR_OK;
            end
            else
            begin
                phase_reg   <= phase_next;
                started_reg <= 1'b1;
                pend_reg    <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            off_reg   <= cur + ONE;
            lead_reg  <= lead_next;
            stop_reg  <= stop_next;
            close_reg <= close_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/xetr_out_stage.sv
// Result register of the end tag recognizer: holds one verdict until taken.
// Depends on xetr_pkg.
`default_nettype none

module xetr_out_stage
    import xetr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire xetr_result_t result,
    output logic              blocked,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              matched,
    output logic [2:0]        error_code,
    output logic [31:0]       error_offset,
    output logic [31:0]       tag_begin,
    output logic [31:0]       raw_end,
    output logic [31:0]       name_begin,
    output logic [31:0]       name_limit
);

    logic         valid_reg;
    xetr_result_t res_reg;

    assign blocked = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign matched      = res_reg.matched;
    assign error_code   = res_reg.error_code;
    assign error_offset = res_reg.error_offset;
    assign tag_begin    = res_reg.tag_begin;
    assign raw_end      = res_reg.raw_end;
    assign name_begin   = res_reg.name_begin;
    assign name_limit   = res_reg.name_limit;

endmodule

`default_nettype wire

### hw/rtl/xml_end_tag_recognizer_core.sv
// Top level of the XML end tag recognizer: input register, scanner, result register.
// Depends on xetr_pkg, xetr_in_stage, xetr_parser and xetr_out_stage.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+------------------------------
//   in      | in_valid, in_stall, text_byte, last_byte, | one message byte a transaction
//           | start_offset                              |
//   out     | out_valid, out_stall, matched, error_code,| one verdict per message
//           | error_offset, tag_begin .. name_limit     |
//
// One byte a cycle while no last byte waits on a stalled result register; when a byte
// leaves the input register, its verdict (last byte only) is loaded into the result register.
// The rate is set by the phase update in the scanner, which advances once per byte.
// Reset clears the phase machine and both valid flags; no clearing pass is needed.
// A stalled verdict holds the result register; input keeps flowing until a
// last byte finds the result register occupied and stalled.
`default_nettype none

module xml_end_tag_recognizer_core
    import xetr_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        last_byte,
    input  wire logic [31:0] start_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             matched,
    output logic [2:0]       error_code,
    output logic [31:0]      error_offset,
    output logic [31:0]      tag_begin,
    output logic [31:0]      raw_end,
    output logic [31:0]      name_begin,
    output logic [31:0]      name_limit
);

    xetr_item_t   item;
    logic         item_valid;
    xetr_result_t result;
    logic         blocked;
    logic         fire;

    // Advance a byte only if its verdict, if any, has somewhere to go.
    assign fire = item_valid && (!blocked || !item.last_byte);

    xetr_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .start_offset (start_offset),
        .fire         (fire),
        .item_valid   (item_valid),
        .item         (item)
    );

    xetr_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    xetr_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && item.last_byte),
        .result       (result),
        .blocked      (blocked),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .error_code   (error_code),
        .error_offset (error_offset),
        .tag_begin    (tag_begin),
        .raw_end      (raw_end),
        .name_begin   (name_begin),
        .name_limit   (name_limit)
    );

endmodule

`default_nettype wire

### hw/rtl/xetr_checker.sv
// Port-level checks for the XML end tag recognizer, bound to the top level.
// Depends on xetr_pkg and xml_end_tag_recognizer_core_macros.svh.
`default_nettype none

`include "xml_end_tag_recognizer_core_macros.svh"

module xetr_checker
    import xetr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        matched,
    input  wire logic [2:0]  error_code,
    input  wire logic [31:0] error_offset,
    input  wire logic [31:0] tag_begin,
    input  wire logic [31:0] raw_end,
    input  wire logic [31:0] name_begin,
    input  wire logic [31:0] name_limit
);

    logic        held;
    logic [35:0] shown;
    logic        ok_code;
    logic        code_known;
    logic        miss;
    logic        hit;
    logic        miss_clear;

    assign held       = out_valid && out_stall;
    assign shown      = {matched, error_code, error_offset};
    assign ok_code    = (error_code == ERR_OK);
    assign code_known = (error_code <= ERR_EXTRA);
    assign miss       = out_valid && !matched;
    assign hit        = out_valid && matched;
    assign miss_clear = ((tag_begin | raw_end | name_begin | name_limit) == 32'd0);

    `XETR_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(shown), "verdict moved")
    `XETR_ASSERT_NOW(a_match_code, clk, rst_n, out_valid, matched == ok_code, "flag vs code")
    `XETR_ASSERT_NOW(a_code_range, clk, rst_n, out_valid, code_known, "code out of range")
    `XETR_ASSERT_NOW(a_miss_zero, clk, rst_n, miss, miss_clear, "offsets on a miss")
    `XETR_ASSERT_NOW(a_match_off, clk, rst_n, hit, error_offset == tag_begin, "match offset")

endmodule

bind xml_end_tag_recognizer_core xetr_checker u_checker (.*);

`default_nettype wire

### tb/sv/tb_xml_end_tag_recognizer_core.sv
// Self-checking bench for xml_end_tag_recognizer_core: streams byte messages through the
// valid/stall channels and checks every verdict against a tag scanner kept in this file.
// Depends on xetr_pkg and the recognizer RTL.
module tb_xml_end_tag_recognizer_core
    import xetr_pkg::*;
();

    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_SLASH,
        SCAN_NAME_HEAD,
        SCAN_NAME,
        SCAN_TRAIL,
        SCAN_WAIT_GT,
        SCAN_DONE
    } scan_phase_t;

    typedef enum int {
        MSG_GOOD,
        MSG_GOOD_TAIL,
        MSG_TRUNC,
        MSG_BAD_NAME,
        MSG_EXTRA,
        MSG_BLANK,
        MSG_NOISE,
        MSG_NO_SLASH
    } msg_kind_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte    = '0;
    logic        last_byte    = 1'b0;
    logic [31:0] start_offset = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        matched;
    logic [2:0]  error_code;
    logic [31:0] error_offset;
    logic [31:0] tag_begin;
    logic [31:0] raw_end;
    logic [31:0] name_begin;
    logic [31:0] name_limit;

    // Tag scanner state, advanced once per accepted transaction
    scan_phase_t scan_phase     = SCAN_LEAD;
    logic [31:0] scan_pos       = '0;
    logic [31:0] scan_base      = '0;
    logic [31:0] scan_lead      = '0;
    logic [31:0] scan_name_stop = '0;
    logic [31:0] scan_close     = '0;
    err_code_t   scan_code      = ERR_OK;
    bit          scan_open      = 1'b0;

    xetr_result_t verdict_q[$];
    logic [7:0]   msg_text[$];
    int           fail_count    = 0;
    int           bytes_sent    = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           hold_reqs     = 0;
    int           hold_seen     = 0;
    int           hold_left     = 0;

    xml_end_tag_recognizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .start_offset (start_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .error_code   (error_code),
        .error_offset (error_offset),
        .tag_begin    (tag_begin),
        .raw_end      (raw_end),
        .name_begin   (name_begin),
        .name_limit   (name_limit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_ws(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit name_head(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (folded >= "a" && folded <= "z") || c == CH_UNDER || c == CH_COLON;
    endfunction

    function automatic bit name_tail(input logic [7:0] c);
        return name_head(c) || (c >= "0" && c <= "9") || c == CH_DASH || c == CH_DOT;
    endfunction

    // Advance the scanner by one byte; return 1 with the verdict on a last byte
    function automatic bit scan_byte(input logic [7:0] c, input logic is_last,
                                     input logic [31:0] offset, output xetr_result_t verdict);
        logic [31:0] pos;
        verdict = '0;
        if (!scan_open)
        begin
            scan_base = offset;
            scan_open = 1'b1;
        end
        pos = scan_pos;
        case (scan_phase)
            SCAN_LEAD:
                if (!is_ws(c))
                begin
                    scan_lead = pos;
                    if (c == CH_LT)
                        scan_phase = SCAN_SLASH;
                    else
                    begin
                        scan_code  = ERR_NO_OPEN;
                        scan_phase = SCAN_DONE;
                    end
                end
            SCAN_SLASH:
                if (c == CH_SLASH)
                    scan_phase = SCAN_NAME_HEAD;
                else
                begin
                    scan_code  = ERR_NO_OPEN;
                    scan_phase = SCAN_DONE;
                end
            SCAN_NAME_HEAD:
                if (name_head(c))
                    scan_phase = SCAN_NAME;
                else
                begin
                    // bad name only counts once a '>' shows up
                    scan_code  = ERR_BAD_NAME;
                    scan_phase = (c == CH_GT) ? SCAN_DONE : SCAN_WAIT_GT;
                end
            SCAN_NAME:
                if (!name_tail(c))
                begin
                    scan_name_stop = pos;
                    if (c == CH_GT)
                    begin
                        scan_close = pos;
                        scan_code  = ERR_OK;
                        scan_phase = SCAN_DONE;
                    end
                    else if (is_ws(c))
                        scan_phase = SCAN_TRAIL;
                    else
                    begin
                        scan_code  = ERR_EXTRA;
                        scan_phase = SCAN_WAIT_GT;
                    end
                end
            SCAN_TRAIL:
                if (c == CH_GT)
                begin
                    scan_close = pos;
                    scan_code  = ERR_OK;
                    scan_phase = SCAN_DONE;
                end
                else if (!is_ws(c))
                begin
                    scan_code  = ERR_EXTRA;
                    scan_phase = SCAN_WAIT_GT;
                end
            SCAN_WAIT_GT:
                if (c == CH_GT)
                    scan_phase = SCAN_DONE;
            default: ;
        endcase
        scan_pos = scan_pos + 1;
        if (!is_last)
            return 1'b0;

        case (scan_phase)
            SCAN_LEAD:
            begin
                verdict.error_code   = ERR_EMPTY;
                verdict.error_offset = scan_base + scan_pos;
            end
            SCAN_SLASH:
            begin
                verdict.error_code   = ERR_NO_OPEN;
                verdict.error_offset = scan_base + scan_lead;
            end
            SCAN_DONE:
            begin
                verdict.error_code = scan_code;
                case (scan_code)
                    ERR_OK:
                    begin
                        verdict.matched      = 1'b1;
                        verdict.error_offset = scan_base + scan_lead;
                        verdict.tag_begin    = scan_base + scan_lead;
                        verdict.raw_end      = scan_base + scan_close + 1;
                        verdict.name_begin   = scan_base + scan_lead + 2;
                        verdict.name_limit   = scan_base + scan_name_stop;
                    end
                    ERR_BAD_NAME: verdict.error_offset = scan_base + scan_lead + 2;
                    ERR_EXTRA:    verdict.error_offset = scan_base + scan_name_stop;
                    default:      verdict.error_offset = scan_base + scan_lead;
                endcase
            end
            default:
            begin
                // no '>' after '</': unterminated wins over any name problem
                verdict.error_code   = ERR_UNTERM;
                verdict.error_offset = scan_base + scan_lead;
            end
        endcase

        scan_phase     = SCAN_LEAD;
        scan_pos       = '0;
        scan_lead      = '0;
        scan_name_stop = '0;
        scan_close     = '0;
        scan_code      = ERR_OK;
        scan_open      = 1'b0;
        return 1'b1;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_verdict();
        xetr_result_t want;
        if (verdict_q.size() == 0)
        begin
            $error("verdict arrived with no message pending");
            fail_count++;
            return;
        end
        want = verdict_q.pop_front();
        compare_field("matched", 32'(want.matched), 32'(matched));
        compare_field("error_code", 32'(want.error_code), 32'(error_code));
        compare_field("error_offset", want.error_offset, error_offset);
        compare_field("tag_begin", want.tag_begin, tag_begin);
        compare_field("raw_end", want.raw_end, raw_end);
        compare_field("name_begin", want.name_begin, name_begin);
        compare_field("name_limit", want.name_limit, name_limit);
    endtask

    // Result side: check each accepted transaction, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_verdict();
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] c, input logic is_last,
                             input logic [31:0] offset);
        xetr_result_t verdict;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= c;
        last_byte    <= is_last;
        start_offset <= offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (scan_byte(c, is_last, offset, verdict))
            verdict_q.push_back(verdict);
        bytes_sent++;
    endtask

    // Offset matters only on the first byte; drive junk on the rest
    task automatic send_message(input logic [31:0] offset);
        for (int i = 0; i < msg_text.size(); i++)
            send_byte(msg_text[i], i == msg_text.size() - 1, (i == 0) ? offset : $urandom);
    endtask

    task automatic send_text(input string s, input logic [31:0] offset);
        msg_text.delete();
        for (int i = 0; i < s.len(); i++)
            msg_text.push_back(s[i]);
        send_message(offset);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'hFFFF_FFFF - $urandom_range(0, 15);
        if (r == 1)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char(input bit head);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (!(head ? name_head(c) : name_tail(c)));
        return c;
    endfunction

    // Byte that breaks a name: not a name character, not blank, not '>'
    function automatic logic [7:0] pick_junk();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (name_tail(c) || is_ws(c) || c == CH_GT);
        return c;
    endfunction

    function automatic msg_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return MSG_GOOD;
        if (r < 55) return MSG_GOOD_TAIL;
        if (r < 67) return MSG_TRUNC;
        if (r < 75) return MSG_BAD_NAME;
        if (r < 83) return MSG_EXTRA;
        if (r < 87) return MSG_BLANK;
        if (r < 95) return MSG_NOISE;
        return MSG_NO_SLASH;
    endfunction

    task automatic build_message(input msg_kind_t kind);
        logic [7:0] c;
        int         n;
        msg_text.delete();
        case (kind)
            MSG_BLANK:
                repeat ($urandom_range(1, 4))
                    msg_text.push_back(pick_blank());
            MSG_NOISE:
                repeat ($urandom_range(1, 8))
                    msg_text.push_back(8'($urandom_range(0, 255)));
            MSG_NO_SLASH:
            begin
                repeat ($urandom_range(0, 2))
                    msg_text.push_back(pick_blank());
                msg_text.push_back(CH_LT);
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_SLASH);
                msg_text.push_back(c);
                repeat ($urandom_range(0, 3))
                    msg_text.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                repeat ($urandom_range(0, 3))
                    msg_text.push_back(pick_blank());
                msg_text.push_back(CH_LT);
                msg_text.push_back(CH_SLASH);
                if (kind == MSG_BAD_NAME)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (name_head(c));
                    msg_text.push_back(($urandom_range(0, 3) == 0) ? CH_GT : c);
                end
                else
                    msg_text.push_back(pick_name_char(1'b1));
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
                repeat (n)
                    msg_text.push_back(pick_name_char(1'b0));
                if (kind == MSG_EXTRA)
                begin
                    repeat ($urandom_range(0, 1))
                        msg_text.push_back(pick_blank());
                    msg_text.push_back(pick_junk());
                    repeat ($urandom_range(0, 2))
                        msg_text.push_back(8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 2))
                    msg_text.push_back(pick_blank());
                // drop the '>' now and then on the broken kinds
                if (!((kind == MSG_EXTRA || kind == MSG_BAD_NAME) && $urandom_range(0, 3) == 0))
                    msg_text.push_back(CH_GT);
                if (kind == MSG_GOOD_TAIL)
                    repeat ($urandom_range(1, 4))
                        msg_text.push_back(8'($urandom_range(0, 255)));
                if (kind == MSG_TRUNC)
                begin
                    n = $urandom_range(1, msg_text.size() - 1);
                    while (msg_text.size() > n)
                        void'(msg_text.pop_back());
                end
            end
        endcase
    endtask

    task automatic run_random(input int item_count);
        int stop_at;
        stop_at = bytes_sent + item_count;
        while (bytes_sent < stop_at)
        begin
            build_message(pick_kind());
            send_message(pick_offset());
        end
    endtask

    task automatic test_special_cases();
        set_idling(0, 0);
        send_text("\t\r\n ", 32'h0000_0010);     // all space
        send_text("x", 32'hFFFF_FFFF);            // no '<'
        send_text("<", 32'h1234_5678);            // too short for '</'
        send_text("</", 32'h8000_0000);           // unterminated
        send_text("</1", 32'h0000_0000);          // unterminated hides bad name
        send_text("</>", 32'h0000_0100);          // bad name closed at once
        send_text("</a!>", 32'h7FFF_FFFF);        // content before '>'
        send_text("</Z >", 32'hFFFF_FFFE);        // match, offsets wrap
    endtask

    task automatic test_sender_idle();
        set_idling(23, 52);
        run_random(700);
    endtask

    task automatic test_receiver_idle();
        set_idling(52, 23);
        run_random(700);
    endtask

    task automatic test_no_idle();
        set_idling(0, 0);
        run_random(400);
    endtask

    // Hold the result side off while bytes keep coming so the input backs up
    task automatic test_output_hold_off();
        set_idling(0, 0);
        hold_reqs <= hold_reqs + 1;
        run_random(150);
    endtask

    task automatic test_drain_pause();
        set_idling(10, 10);
        run_random(25);
        repeat (4)
        begin
            pause_until_drained();
            run_random(25);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_sender_idle();
        test_receiver_idle();
        test_no_idle();
        test_output_hold_off();
        test_drain_pause();
        pause_until_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
